### hdl/assert_macros.svh
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LKV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define LKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LKV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define LKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/lkv_pkg.sv
// shared constants and types of the lru key-value cache
`timescale 1ns / 1ps
package lkv_pkg;
    localparam int LKV_MAX_ENTRIES = 16;
    localparam int DATA_W          = 32;
    localparam int CAP_W           = 5;
    localparam int PADDR_W         = 2;
    localparam int PDATA_W         = 32;

    localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
    localparam logic [PADDR_W-1:0] CAP_ADDR  = 2'd0;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic load;
        logic cmp;
        logic upd;
    } t_cmd;
endpackage

### hdl/lkv_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface lkv_req_if;
    import lkv_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, opcode, key, value, input ready);
    modport sink   (input valid, opcode, key, value, output ready);
endinterface

interface lkv_rsp_if;
    import lkv_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;

    modport source (output valid, hit, read_value, evicted, input ready);
    modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

### hdl/lru_key_value_cache_core.sv
// lru key-value cache: one transfer in, one result out per item
// result path: accept loads the item, compare registers the match, update writes the result
// a new request is taken during the previous update if the result register is free
// the compare-then-shift pass over the slot chain paces requests; an untaken result stalls it
// reset (synchronous, active low): all slots invalid, occupancy zero, capacity 16
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lru_key_value_cache_core #(
    parameter int MAX_ENTRIES = lkv_pkg::LKV_MAX_ENTRIES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lkv_pkg::PADDR_W-1:0]  paddr,
    input  logic [lkv_pkg::PDATA_W-1:0]  pwdata,
    output logic [lkv_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    lkv_req_if.sink                      i_req,
    lkv_rsp_if.source                    o_rsp
);
    import lkv_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    t_cmd             w_cmd;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && (paddr == CAP_ADDR)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr == CAP_ADDR) ? PDATA_W'(r_capacity) : '0;

    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    lkv_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_capacity   (r_capacity),
        .i_opcode     (i_req.opcode),
        .i_key        (i_req.key),
        .i_value      (i_req.value),
        .o_hit        (o_rsp.hit),
        .o_read_value (o_rsp.read_value),
        .o_evicted    (o_rsp.evicted)
    );

    `LKV_ASSERT_NEXT(a_accept_to_cmp, i_clk, i_rst_n, i_req.valid && i_req.ready, w_cmd.cmp, "accepted request not compared next cycle")
    `LKV_ASSERT_IMPLY(a_cmp_single, i_clk, i_rst_n, w_cmd.cmp, !i_req.ready, "request taken during the compare cycle")
    `LKV_ASSERT_NEXT(a_upd_to_rsp, i_clk, i_rst_n, w_cmd.upd, o_rsp.valid, "update did not present a result")
    `LKV_ASSERT_IMPLY(a_upd_slot_free, i_clk, i_rst_n, w_cmd.upd, !o_rsp.valid || o_rsp.ready, "update overwrote an untaken result")
endmodule

### hdl/lkv_ctrl.sv
// sequencing state machine: accept, compare, update and result hand-off
`timescale 1ns / 1ps
module lkv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lkv_pkg::t_cmd o_cmd
);
    import lkv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;
    logic   w_upd;
    logic   w_load;

    assign w_out_free = !r_out_valid || i_out_ready;
    // update only when the result register can take the new result
    assign w_upd      = (r_state == S_UPD) && w_out_free;
    assign o_in_ready = (r_state == S_IDLE) || w_upd;
    assign w_load     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_upd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_load) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_upd) begin
                        r_state <= w_load ? S_CMP : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = w_load;
    assign o_cmd.cmp   = (r_state == S_CMP);
    assign o_cmd.upd   = w_upd;
endmodule

### hdl/lkv_datapath.sv
// slot chain with parallel key compare, recency shift and result register
`timescale 1ns / 1ps
module lkv_datapath #(
    parameter int MAX_ENTRIES = lkv_pkg::LKV_MAX_ENTRIES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lkv_pkg::t_cmd                    i_cmd,
    input  logic [lkv_pkg::CAP_W-1:0]        i_capacity,
    input  logic                             i_opcode,
    input  logic signed [lkv_pkg::DATA_W-1:0] i_key,
    input  logic signed [lkv_pkg::DATA_W-1:0] i_value,
    output logic                             o_hit,
    output logic signed [lkv_pkg::DATA_W-1:0] o_read_value,
    output logic                             o_evicted
);
    import lkv_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    // current item
    logic              r_op;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_value;

    // slots, index 0 most recent
    logic              r_slot_valid [MAX_ENTRIES];
    logic [DATA_W-1:0] r_slot_key   [MAX_ENTRIES];
    logic [DATA_W-1:0] r_slot_value [MAX_ENTRIES];
    logic [OCC_W-1:0]  r_occ;

    // compare stage results
    logic              r_hit;
    logic [IDX_W-1:0]  r_pos;
    logic              r_full;
    logic [DATA_W-1:0] r_hit_value;

    // result register
    logic              r_out_hit;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_evicted;

    logic [MAX_ENTRIES-1:0] w_match;
    logic [IDX_W-1:0]       w_enc;
    logic [DATA_W-1:0]      w_hit_value;
    logic [CMP_W-1:0]       w_cap_ext;
    logic [CMP_W-1:0]       w_eff_cap;
    logic                   w_full;
    logic [IDX_W-1:0]       w_last;
    logic                   w_change;
    logic [DATA_W-1:0]      w_entry_value;

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_match[i] = r_slot_valid[i] && (r_slot_key[i] == r_key);
        end
    end

    // keys are unique among valid slots, so at most one match bit is set
    always_comb begin
        w_enc       = '0;
        w_hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_match[i]) begin
                w_enc       = w_enc | IDX_W'(i);
                w_hit_value = w_hit_value | r_slot_value[i];
            end
        end
    end

    // zero capacity counts as one, anything above the slot count as the slot count
    always_comb begin
        w_cap_ext = CMP_W'(i_capacity);
        if (w_cap_ext == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(MAX_ENTRIES)) begin
            w_eff_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            w_eff_cap = w_cap_ext;
        end
    end

    assign w_full = CMP_W'(r_occ) >= w_eff_cap;
    assign w_last = w_full ? IDX_W'(r_occ - 1'b1) : IDX_W'(r_occ);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.cmp) begin
            r_hit       <= |w_match;
            r_pos       <= (|w_match) ? w_enc : w_last;
            r_full      <= w_full;
            r_hit_value <= w_hit_value;
        end
        if (i_cmd.upd) begin
            r_out_hit     <= r_hit;
            r_out_value   <= ((r_op == OP_GET) && r_hit) ? r_hit_value : '0;
            r_out_evicted <= (r_op == OP_PUT) && !r_hit && r_full;
        end
    end

    // a get miss leaves the slots alone
    assign w_change      = i_cmd.upd && ((r_op == OP_PUT) || r_hit);
    assign w_entry_value = (r_op == OP_PUT) ? r_value : r_hit_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.upd && (r_op == OP_PUT) && !r_hit && !r_full) begin
            r_occ <= r_occ + 1'b1;
        end
    end

    // cells from the head up to and including the target position shift one place towards the tail
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic w_shift;
        assign w_shift = w_change && (IDX_W'(g) <= r_pos);

        if (g == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_slot_valid[g] <= 1'b0;
                end else if (w_shift) begin
                    r_slot_valid[g] <= 1'b1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_shift) begin
                    r_slot_key[g]   <= r_key;
                    r_slot_value[g] <= w_entry_value;
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_slot_valid[g] <= 1'b0;
                end else if (w_shift) begin
                    r_slot_valid[g] <= r_slot_valid[g-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_shift) begin
                    r_slot_key[g]   <= r_slot_key[g-1];
                    r_slot_value[g] <= r_slot_value[g-1];
                end
            end
        end
    end

    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_value;
    assign o_evicted    = r_out_evicted;
endmodule
